[hw/rtl/vkp_pkg.sv]
// ----------------------------------------------------------------------------
// vkp_pkg
// Types, codes and the supported-keyword table of the VPD keyword parser.
// ----------------------------------------------------------------------------
package vkp_pkg;

  localparam int unsigned TableSize = 12;

  localparam logic [15:0] NameEnd   = 16'h5046;  // "PF"
  localparam logic [7:0]  PoundChar = 8'h23;     // '#'

  // Result kinds (tuser)
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  // Encoding classes
  typedef enum logic [2:0] {
    CLASS_ASCII = 3'd0,
    CLASS_HEX   = 3'd1,
    CLASS_MAC   = 3'd2,
    CLASS_DATE  = 3'd3,
    CLASS_UUID  = 3'd4,
    CLASS_NONE  = 3'd5
  } class_e;

  // Walker phases, one-hot
  typedef enum logic [5:0] {
    PH_DONE  = 6'b000001,
    PH_NAME1 = 6'b000010,
    PH_NAME2 = 6'b000100,
    PH_LEN1  = 6'b001000,
    PH_LEN2  = 6'b010000,
    PH_DATA  = 6'b100000
  } phase_e;

  typedef logic [15:0] kw_name_t;

  localparam kw_name_t KwNames [TableSize] = '{
    16'h4452, 16'h504E, 16'h534E, 16'h4343, 16'h4857, 16'h4231,  // DR PN SN CC HW B1
    16'h564E, 16'h4D42, 16'h4D4D, 16'h5544, 16'h5650, 16'h5653   // VN MB MM UD VP VS
  };

  localparam class_e KwClasses [TableSize] = '{
    CLASS_ASCII, CLASS_ASCII, CLASS_ASCII, CLASS_ASCII, CLASS_HEX,   CLASS_MAC,
    CLASS_ASCII, CLASS_DATE,  CLASS_ASCII, CLASS_UUID,  CLASS_ASCII, CLASS_ASCII
  };

  // Register map (byte address / 4)
  localparam logic [0:0] RegFilterEnable = 1'b0;

endpackage

[hw/rtl/vpd_keyword_tlv_parser.sv]
// ----------------------------------------------------------------------------
// vpd_keyword_tlv_parser
// Walks the keyword list of a VPD record, one byte per transfer.
// ----------------------------------------------------------------------------
// The parser takes one raw byte of a record keyword area per transfer and
// sustains one byte per clock while no result waits unaccepted. Each byte
// lands in an input register. The walker state machine then consumes it
// and, when it yields a result, loads the result register. A result thus
// passes through the input register and then the result register.
// Both registers move together whenever the result register is empty or
// being drained. While a result waits unaccepted the walker holds, and the
// input stalls once its register is full. tuser on the input marks the first
// name byte of a list and restarts the walk from any point. Each keyword is
// a two-character name, a one-byte length (two bytes, little-endian, when
// the name starts with '#'), then its data bytes. Every data byte goes out
// with the name, its index, its encoding class and tlast on the final byte.
// A zero-length keyword gives one empty result with tlast set. "PF" gives an
// end-of-list result, after which bytes are dropped until the next list
// start. With filter_enable set (reset value), keywords outside the
// supported table are consumed without any result. filter_enable sits at
// APB address 0, bit 0.
// ----------------------------------------------------------------------------
module vpd_keyword_tlv_parser (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] list_start

  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] keyword_name, [18:16] encoding_class, [26:19] value_byte,
  // [42:27] byte_index, [47:43] zero
  output logic [47:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast,   // last_of_keyword

  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import vkp_pkg::*;

  // --------------------------------------------------------------------------
  // Config register
  // --------------------------------------------------------------------------
  logic filter_q;
  logic reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == RegFilterEnable);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_q <= 1'b1;
    end else if (psel && penable && pwrite && reg_hit) begin
      filter_q <= pwdata[0];
    end
  end

  assign prdata = reg_hit ? {31'd0, filter_q} : 32'd0;

  // --------------------------------------------------------------------------
  // Pipeline handshake: input register -> result register
  // --------------------------------------------------------------------------
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_start_q;
  logic       out_vld_q;
  logic       out_free;
  logic       advance;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign advance       = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser;
    end
  end

  // --------------------------------------------------------------------------
  // Walker state
  // --------------------------------------------------------------------------
  phase_e      phase_q, phase_d;
  kw_name_t    name_q, name_d;
  logic [7:0]  len_lo_q, len_lo_d;
  logic [15:0] remain_q, remain_d;
  logic [15:0] index_q, index_d;
  class_e      class_q, class_d;
  class_e      lookup_class;
  kw_name_t    full_name;
  logic [15:0] length;
  logic        passes;

  // Result candidate
  logic        emit;
  kind_e       r_kind;
  logic [7:0]  r_value;
  logic [15:0] r_index;
  logic        r_last;

  assign full_name = {name_q[15:8], in_byte_q};
  assign passes    = !filter_q || (class_q != CLASS_NONE);

  vkp_class_lookup u_lookup (
    .name_i  (full_name),
    .class_o (lookup_class)
  );

  always_comb begin
    phase_d  = phase_q;
    name_d   = name_q;
    len_lo_d = len_lo_q;
    remain_d = remain_q;
    index_d  = index_q;
    class_d  = class_q;
    emit     = 1'b0;
    r_kind   = KIND_DATA;
    r_value  = 8'd0;
    r_index  = 16'd0;
    r_last   = 1'b0;
    length   = 16'd0;

    if (in_start_q) begin
      // list start restarts from any phase
      name_d  = {in_byte_q, 8'd0};
      phase_d = PH_NAME2;
    end else begin
      case (phase_q)
        PH_NAME1: begin
          name_d  = {in_byte_q, 8'd0};
          phase_d = PH_NAME2;
        end
        PH_NAME2: begin
          name_d = full_name;
          if (full_name == NameEnd) begin
            class_d = CLASS_NONE;
            phase_d = PH_DONE;
            emit    = 1'b1;
            r_kind  = KIND_END;
          end else begin
            class_d = lookup_class;
            phase_d = PH_LEN1;
          end
        end
        PH_LEN1, PH_LEN2: begin
          if (phase_q == PH_LEN1) begin
            len_lo_d = in_byte_q;
            length   = {8'd0, in_byte_q};
          end else begin
            length   = {in_byte_q, len_lo_q};
          end
          if (phase_q == PH_LEN1 && name_q[15:8] == PoundChar) begin
            phase_d = PH_LEN2;
          end else if (length == 16'd0) begin
            // empty keyword
            phase_d = PH_NAME1;
            emit    = passes;
            r_kind  = KIND_EMPTY;
            r_last  = 1'b1;
          end else begin
            remain_d = length;
            index_d  = 16'd0;
            phase_d  = PH_DATA;
          end
        end
        PH_DATA: begin
          emit     = passes;
          r_kind   = KIND_DATA;
          r_value  = in_byte_q;
          r_index  = index_q;
          r_last   = (remain_q == 16'd1);
          remain_d = remain_q - 16'd1;
          index_d  = index_q + 16'd1;
          if (remain_d == 16'd0) begin
            phase_d = PH_NAME1;
          end
        end
        default: begin
          // done or an unused code: wait for list start
          phase_d = PH_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_DONE;
      name_q   <= '0;
      len_lo_q <= '0;
      remain_q <= '0;
      index_q  <= '0;
      class_q  <= CLASS_NONE;
    end else if (advance) begin
      phase_q  <= phase_d;
      name_q   <= name_d;
      len_lo_q <= len_lo_d;
      remain_q <= remain_d;
      index_q  <= index_d;
      class_q  <= class_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  kind_e       o_kind_q;
  kw_name_t    o_name_q;
  class_e      o_class_q;
  logic [7:0]  o_value_q;
  logic [15:0] o_index_q;
  logic        o_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= advance && emit;
    end
  end

  // name and class carry their updated values, as the end-of-list result needs
  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      o_kind_q  <= r_kind;
      o_name_q  <= name_d;
      o_class_q <= class_d;
      o_value_q <= r_value;
      o_index_q <= r_index;
      o_last_q  <= r_last;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'd0, o_index_q, o_value_q, o_class_q, o_name_q};
  assign m_axis_tuser  = o_kind_q;
  assign m_axis_tlast  = o_last_q;

endmodule

[hw/rtl/vkp_class_lookup.sv]
// ----------------------------------------------------------------------------
// vkp_class_lookup
// Matches a keyword name against the supported-keyword table.
// ----------------------------------------------------------------------------
module vkp_class_lookup (
  input  vkp_pkg::kw_name_t name_i,
  output vkp_pkg::class_e   class_o
);
  import vkp_pkg::*;

  // Table names are unique, so at most one entry hits.
  always_comb begin
    class_o = CLASS_NONE;
    for (int i = 0; i < TableSize; i++) begin
      if (KwNames[i] == name_i) begin
        class_o = KwClasses[i];
      end
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for vpd_keyword_tlv_parser: streams VPD keyword lists
// byte by byte, predicts each result transfer and checks it field by field.
// ----------------------------------------------------------------------------
module testbench;
  import vkp_pkg::*;

  localparam int          CycleLimit   = 4_000_000;  // run ends here if stuck
  localparam int          DrainCycles  = 8;
  localparam int          MaxShown     = 10;
  localparam logic [2:0]  FilterAddr   = {RegFilterEnable, 2'b00};

  // Supported keyword table, kept independently of the RTL package
  localparam logic [15:0] SupportedNames [12] = '{
    "DR", "PN", "SN", "CC", "HW", "B1", "VN", "MB", "MM", "UD", "VP", "VS"
  };
  localparam class_e SupportedClasses [12] = '{
    CLASS_ASCII, CLASS_ASCII, CLASS_ASCII, CLASS_ASCII, CLASS_HEX,  CLASS_MAC,
    CLASS_ASCII, CLASS_DATE,  CLASS_ASCII, CLASS_UUID,  CLASS_ASCII, CLASS_ASCII
  };

  // One result transfer as seen on the master side
  typedef struct packed {
    kind_e       kind;
    logic [15:0] name;
    class_e      cls;
    logic [7:0]  value;
    logic [15:0] index;
    logic        last;
  } kw_result_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;

  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tuser  = 1'b0;
  logic        s_axis_tready;

  logic        m_axis_tvalid;
  logic        rx_ready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  always #2 clk_i = ~clk_i;

  vpd_keyword_tlv_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),        // [7:0] data_byte
    .s_axis_tuser  (s_tuser),        // [0] list_start
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (rx_ready),
    .m_axis_tdata  (m_axis_tdata),   // [15:0] name, [18:16] class, [26:19] value,
                                     // [42:27] index, [47:43] zero
    .m_axis_tuser  (m_axis_tuser),   // [1:0] kind
    .m_axis_tlast  (m_axis_tlast),   // last_of_keyword
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // --------------------------------------------------------------------------
  // Shared bookkeeping
  // --------------------------------------------------------------------------
  kw_result_t  pending_results [$];   // predicted, not yet seen on the bus
  int          errors         = 0;
  int          cycle_count    = 0;
  int          bytes_sent     = 0;
  int          walked_bytes   = 0;    // bytes that were not just dropped
  int          results_seen   = 0;
  int          filter_writes  = 0;
  int          burst_left     = 0;

  // Walker copy used for prediction
  logic        filter_on  = 1'b1;
  phase_e      walk_phase = PH_DONE;
  logic [15:0] kw_name    = '0;
  logic [7:0]  len_low    = '0;
  logic [15:0] bytes_left = '0;
  logic [15:0] byte_pos   = '0;
  class_e      kw_class   = CLASS_NONE;

  // Advance the walker copy by one accepted byte; queue the result it yields.
  task automatic walk_byte(input logic [7:0] b, input logic st);
    kw_result_t  r;
    logic        emit;
    logic        open_kw;
    logic        visible;
    logic [15:0] len;
    r       = '0;
    emit    = 1'b0;
    open_kw = 1'b0;
    len     = '0;
    visible = !filter_on || kw_class != CLASS_NONE;
    if (!st && walk_phase == PH_DONE) begin
      return;                          // waiting for a list start: dropped
    end
    walked_bytes++;
    if (st) begin
      // list start restarts the walk from any phase
      kw_name    = {b, 8'h00};
      walk_phase = PH_NAME2;
    end else begin
      case (walk_phase)
        PH_NAME1: begin
          kw_name    = {b, 8'h00};
          walk_phase = PH_NAME2;
        end
        PH_NAME2: begin
          kw_name[7:0] = b;
          if (kw_name == NameEnd) begin
            kw_class   = CLASS_NONE;
            walk_phase = PH_DONE;
            emit       = 1'b1;
            r.kind     = KIND_END;
          end else begin
            kw_class = CLASS_NONE;
            for (int i = 0; i < 12; i++) begin
              if (SupportedNames[i] == kw_name) kw_class = SupportedClasses[i];
            end
            walk_phase = PH_LEN1;
          end
        end
        PH_LEN1: begin
          len_low = b;
          if (kw_name[15:8] == PoundChar) begin
            walk_phase = PH_LEN2;
          end else begin
            open_kw = 1'b1;
            len     = {8'h00, b};
          end
        end
        PH_LEN2: begin
          open_kw = 1'b1;
          len     = {b, len_low};
        end
        PH_DATA: begin
          if (visible) begin
            emit    = 1'b1;
            r.kind  = KIND_DATA;
            r.value = b;
            r.index = byte_pos;
            r.last  = (bytes_left == 16'd1);
          end
          bytes_left = bytes_left - 16'd1;
          byte_pos   = byte_pos + 16'd1;
          if (bytes_left == '0) walk_phase = PH_NAME1;
        end
        default: walk_phase = PH_DONE;
      endcase
    end
    if (open_kw) begin
      if (len == '0) begin
        // zero length: one empty result, next name follows directly
        walk_phase = PH_NAME1;
        if (visible) begin
          emit   = 1'b1;
          r.kind = KIND_EMPTY;
          r.last = 1'b1;
        end
      end else begin
        bytes_left = len;
        byte_pos   = '0;
        walk_phase = PH_DATA;
      end
    end
    if (emit) begin
      r.name = kw_name;
      r.cls  = kw_class;
      pending_results = {pending_results, r};
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps in between
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic st);
    int gap;
    if (burst_left == 0) begin
      // a third of the bursts follow back to back; a few gaps are long
      gap = ($urandom_range(0, 2) == 0) ? 0 :
            $urandom_range(1, ($urandom_range(0, 9) == 0) ? 12 : 3);
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= st;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
    walk_byte(b, st);
  endtask

  // Name, length (two bytes for '#' names) and data; keep > 0 cuts it short.
  task automatic send_keyword(input logic [15:0] nm, input logic [15:0] len,
                              input logic first, input int keep);
    logic [7:0] seq [$];
    int         n_data;
    n_data = (nm[15:8] == PoundChar) ? int'(len) : int'(len[7:0]);
    seq    = '{nm[15:8], nm[7:0], len[7:0]};
    if (nm[15:8] == PoundChar) seq = {seq, len[15:8]};
    repeat (n_data) seq = {seq, 8'($urandom)};
    if (keep > 0 && keep < seq.size()) seq = seq[0:keep-1];
    foreach (seq[i]) send_byte(seq[i], first && i == 0);
  endtask

  task automatic send_end(input logic first);
    send_byte(NameEnd[15:8], first);
    send_byte(NameEnd[7:0], 1'b0);
  endtask

  // Stop sending and let every predicted result come out.
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // APB write of filter_enable followed by a read-back.
  task automatic set_filter(input logic en);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FilterAddr;
    pwdata  <= {31'b0, en};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    filter_on = en;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[0] !== en) begin
      errors++;
      if (errors <= MaxShown)
        $display("filter_enable read-back: expected %b, got %b", en, prdata[0]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    filter_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset filter setting: dropped bytes while waiting, a passing keyword,
  // an empty one, filtered data and a filtered empty keyword, a restart in the
  // middle of data straight into the end name, then a byte after the end.
  task automatic test_filtered_walk();
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_keyword("DR", 16'd2, 1'b1, 0);
    send_keyword("PN", 16'd0, 1'b0, 0);
    send_keyword("ZZ", 16'd1, 1'b0, 0);
    send_keyword("QQ", 16'd0, 1'b0, 0);
    send_keyword("B1", 16'd3, 1'b0, 4);
    send_end(1'b1);
    send_byte(8'h5A, 1'b0);
    wait_drain();
  endtask

  // Filter off: unlisted names pass, '#' names take a two-byte length.
  task automatic test_unfiltered_walk();
    set_filter(1'b0);
    send_keyword("ZZ", 16'd0, 1'b1, 0);
    send_keyword({PoundChar, 8'h51}, 16'd2, 1'b0, 0);
    send_keyword("UD", 16'd1, 1'b0, 0);
    send_end(1'b0);
    wait_drain();
  endtask

  // Long '#' keyword: both length bytes count and the index crosses 0xFF.
  task automatic test_longest_keyword();
    send_keyword({PoundChar, 8'h4C}, 16'h0104, 1'b1, 0);
    send_end(1'b0);
    wait_drain();
  endtask

  // One random list: mostly well formed, some cut short, some pure noise.
  task automatic send_random_list();
    int          n_kw;
    int          pick;
    int          keep;
    logic [15:0] nm;
    logic [15:0] len;
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 12)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
      return;
    end
    n_kw = $urandom_range(1, 6);
    for (int k = 0; k < n_kw; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)      nm = SupportedNames[$urandom_range(0, 11)];
      else if (pick < 70) nm = {PoundChar, 8'($urandom)};
      else if (pick < 78) nm = {NameEnd[15:8], 8'($urandom)};  // may hit the end name
      else                nm = 16'($urandom);
      pick = $urandom_range(0, 99);
      len  = (pick < 80) ? 16'($urandom_range(0, 6)) :
             (pick < 97) ? 16'($urandom_range(7, 40)) : 16'($urandom_range(41, 255));
      keep = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 4) : 0;
      send_keyword(nm, len, k == 0, keep);
      if (keep != 0) return;            // abandoned: next list restarts the walk
    end
    if ($urandom_range(0, 6) != 0) begin
      send_end(1'b0);
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
    end
  endtask

  task automatic test_random_lists(input logic en, input int n_bytes);
    int stop_at;
    set_filter(en);
    stop_at = walked_bytes + n_bytes;
    while (walked_bytes < stop_at) send_random_list();
    wait_drain();
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall pattern changes with the cycle count; also the run limit
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_side
    kw_result_t seen;
    kw_result_t want;
    cycle_count++;
    if (rst_ni && m_axis_tvalid && rx_ready) begin
      results_seen++;
      seen.kind  = kind_e'(m_axis_tuser);
      seen.name  = m_axis_tdata[15:0];
      seen.cls   = class_e'(m_axis_tdata[18:16]);
      seen.value = m_axis_tdata[26:19];
      seen.index = m_axis_tdata[42:27];
      seen.last  = m_axis_tlast;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MaxShown)
          $display("unexpected result: kind %0d name %h class %0d value %h index %0d last %b",
                   seen.kind, seen.name, seen.cls, seen.value, seen.index, seen.last);
      end else begin
        want = pending_results.pop_front();
        if (seen !== want || m_axis_tdata[47:43] !== '0) begin
          errors++;
          if (errors <= MaxShown)
            $display({"result mismatch (exp/got): kind %0d/%0d name %h/%h class %0d/%0d ",
                      "value %h/%h index %0d/%0d last %b/%b pad %h"},
                     want.kind, seen.kind, want.name, seen.name, want.cls, seen.cls,
                     want.value, seen.value, want.index, seen.index, want.last, seen.last,
                     m_axis_tdata[47:43]);
        end
      end
    end
    case (cycle_count[9:8])
      2'd0:    rx_ready <= 1'b1;
      2'd1:    rx_ready <= ($urandom_range(0, 3) != 0);
      2'd2:    rx_ready <= ($urandom_range(0, 3) == 0);
      default: rx_ready <= (cycle_count[3:0] < 4'd9);   // regular stalls
    endcase
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_filtered_walk();
    test_unfiltered_walk();
    test_longest_keyword();
    test_random_lists(1'b1, 150);
    test_random_lists(1'b0, 150);
    test_random_lists(1'b1, 150);
    $display("Walked %0d of %0d input transfers and checked %0d result transfers,",
             walked_bytes, bytes_sent, results_seen);
    $display("including a 260-byte '#' keyword, over %0d filter_enable writes.",
             filter_writes);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/vkp_pkg.sv
hw/rtl/vkp_class_lookup.sv
hw/rtl/vpd_keyword_tlv_parser.sv
tb/testbench.sv
